### rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is off while reset is active.
`define PRST_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Concurrent assertion that also runs through reset.
`define PRST_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### rtl/prst_pkg.sv
// Types, constants and round functions of the PRESENT-80 cipher block.
`timescale 1ns / 1ps
package prst_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_AW       = 5;

    // Register select: paddr bit 3 picks the register
    localparam logic IDX_KEY_UPPER = 1'b0;
    localparam logic IDX_KEY_LOWER = 1'b1;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef logic [ROUND_COUNT-1:0][63:0] rk_array_t;

    typedef struct packed {
        logic        valid;
        logic        func;
        logic [63:0] data;
    } stage_t;

    typedef struct packed {
        logic        start;
        logic [79:0] key;
    } ks_ctrl_t;

    typedef struct packed {
        logic ready;
    } ks_status_t;

    typedef enum logic {
        KS_BUILD,
        KS_READY
    } ks_state_t;

    function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] sbox_inv(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'h5;
            4'h1: y = 4'hE;
            4'h2: y = 4'hF;
            4'h3: y = 4'h8;
            4'h4: y = 4'hC;
            4'h5: y = 4'h1;
            4'h6: y = 4'h2;
            4'h7: y = 4'hD;
            4'h8: y = 4'hB;
            4'h9: y = 4'h4;
            4'hA: y = 4'h6;
            4'hB: y = 4'h3;
            4'hC: y = 4'h0;
            4'hD: y = 4'h7;
            4'hE: y = 4'h9;
            default: y = 4'hA;
        endcase
        return y;
    endfunction

    function automatic logic [63:0] sub_fwd(input logic [63:0] x);
        logic [63:0] y;
        for (int n = 0; n < 16; n++) begin
            y[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
        end
        return y;
    endfunction

    function automatic logic [63:0] sub_inv(input logic [63:0] x);
        logic [63:0] y;
        for (int n = 0; n < 16; n++) begin
            y[4*n +: 4] = sbox_inv(x[4*n +: 4]);
        end
        return y;
    endfunction

    // Bit i moves to 16*i mod 63; bit 63 stays.
    function automatic logic [63:0] perm_fwd(input logic [63:0] x);
        logic [63:0] y;
        y[63] = x[63];
        for (int i = 0; i < 63; i++) begin
            y[(i * 16) % 63] = x[i];
        end
        return y;
    endfunction

    // Inverse wiring: bit i moves to 4*i mod 63.
    function automatic logic [63:0] perm_inv(input logic [63:0] x);
        logic [63:0] y;
        y[63] = x[63];
        for (int i = 0; i < 63; i++) begin
            y[(i * 4) % 63] = x[i];
        end
        return y;
    endfunction

    // Rotate left by 61, S-box on the top nibble, counter into bits 19..15.
    function automatic logic [79:0] key_update(input logic [79:0] k,
                                               input logic [4:0]  rc);
        logic [79:0] t;
        t = {k[18:0], k[79:19]};
        t[79:76] = sbox_fwd(t[79:76]);
        t[19:15] = t[19:15] ^ rc;
        return t;
    endfunction

endpackage

### rtl/prst_key_sched.sv
// Round key store and the sequencer that rebuilds it from the cipher key.
`timescale 1ns / 1ps
module prst_key_sched (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  prst_pkg::ks_ctrl_t    ctrl,
    output prst_pkg::ks_status_t  status,
    output prst_pkg::rk_array_t   rkeys
);

    prst_pkg::ks_state_t state_reg, state_next;
    logic [prst_pkg::RK_AW-1:0] cnt_reg, cnt_next;
    logic [79:0] key_reg, key_next;
    prst_pkg::rk_array_t store_reg;
    logic write_en;

    localparam logic [prst_pkg::RK_AW-1:0] CNT_LAST = prst_pkg::RK_AW'(prst_pkg::ROUND_COUNT - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prst_pkg::KS_BUILD: begin
                if (!ctrl.start && cnt_reg == CNT_LAST) begin
                    state_next = prst_pkg::KS_READY;
                end
            end
            prst_pkg::KS_READY: begin
                if (ctrl.start) begin
                    state_next = prst_pkg::KS_BUILD;
                end
            end
            default: state_next = prst_pkg::KS_BUILD;
        endcase
    end

    always_comb begin
        write_en     = 1'b0;
        status.ready = 1'b0;
        case (state_reg)
            prst_pkg::KS_BUILD: write_en     = 1'b1;
            prst_pkg::KS_READY: status.ready = 1'b1;
            default: write_en = 1'b0;
        endcase
    end

    // A new key restarts the sweep from round 0
    always_comb begin
        if (ctrl.start) begin
            cnt_next = '0;
            key_next = ctrl.key;
        end else if (write_en) begin
            cnt_next = cnt_reg + 1'b1;
            key_next = prst_pkg::key_update(key_reg, cnt_reg + 1'b1);
        end else begin
            cnt_next = cnt_reg;
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prst_pkg::KS_BUILD;
            cnt_reg   <= '0;
            key_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            key_reg   <= key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_en && !ctrl.start) begin
            store_reg[cnt_reg] <= key_reg[79:16];
        end
    end

    assign rkeys = store_reg;

endmodule

### rtl/prst_round.sv
// One registered cipher round, forward or inverse by the item's function bit.
`timescale 1ns / 1ps
module prst_round (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  prst_pkg::stage_t  stage_in,
    input  logic [63:0]       enc_key,
    input  logic [63:0]       dec_key,
    input  logic [63:0]       fin_key,
    output prst_pkg::stage_t  stage_out
);

    logic        valid_reg;
    logic        func_reg;
    logic [63:0] data_reg, data_next;

    // fin_key is zero except in the last stage, where it closes encryption
    always_comb begin
        if (stage_in.func == prst_pkg::FUNC_DECRYPT) begin
            data_next = prst_pkg::sub_inv(prst_pkg::perm_inv(stage_in.data)) ^ dec_key;
        end else begin
            data_next = prst_pkg::perm_fwd(prst_pkg::sub_fwd(stage_in.data ^ enc_key))
                        ^ fin_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            func_reg <= stage_in.func;
            data_reg <= data_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.func  = func_reg;
    assign stage_out.data  = data_reg;

endmodule

### rtl/present80_block_cipher_top.sv
// Top level of the pipelined PRESENT-80 encrypt/decrypt block.
`timescale 1ns / 1ps
// Usage
//   Input channel s_valid/s_ready carries s_func (0 encrypt, 1 decrypt) and
//   s_data_block; result channel m_valid/m_ready carries m_result_block.
//   The 80-bit key is written over the APB port: key_upper at 0x0 (bits
//   79..64), key_lower at 0x8 (bits 63..0). Write keys only while no block
//   is in flight.
// Timing
//   An entry register and 31 round stages, one PRESENT round each, form a
//   32-stage pipeline, and a new block may enter every cycle (one item per
//   cycle sustained) while the result side is not stalled and the round
//   key store is ready.
// Reset and key changes
//   After reset and after every key write the round key store is rebuilt,
//   one round key per cycle; s_ready stays low meanwhile.
//   Reset clears all valid bits; key registers return to zero.
// Stalls
//   When a result waits with m_ready low the whole pipeline holds and
//   s_ready drops; nothing is dropped or repeated.
module present80_block_cipher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [63:0] s_data_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_block,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int NR = prst_pkg::ROUND_COUNT - 1;

    logic [15:0] key_upper_reg;
    logic [63:0] key_lower_reg;
    logic        cfg_wr;
    logic        advance;

    prst_pkg::ks_ctrl_t   ks_ctrl;
    prst_pkg::ks_status_t ks_status;
    prst_pkg::rk_array_t  rk;
    prst_pkg::stage_t     stage [prst_pkg::ROUND_COUNT];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == prst_pkg::IDX_KEY_UPPER) begin
                key_upper_reg <= pwdata[15:0];
            end else begin
                key_lower_reg <= pwdata;
            end
        end
    end

    always_comb begin
        ks_ctrl.start = cfg_wr;
        if (paddr[3] == prst_pkg::IDX_KEY_UPPER) begin
            ks_ctrl.key = {pwdata[15:0], key_lower_reg};
        end else begin
            ks_ctrl.key = {key_upper_reg, pwdata};
        end
    end

    always_comb begin
        if (paddr[3] == prst_pkg::IDX_KEY_UPPER) begin
            prdata = {48'd0, key_upper_reg};
        end else begin
            prdata = key_lower_reg;
        end
    end

    prst_key_sched u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ks_ctrl),
        .status     (ks_status),
        .rkeys      (rk)
    );

    // Advance the whole pipeline unless a result waits
    assign advance = !m_valid || m_ready;
    assign s_ready = advance && ks_status.ready;

    // Entry stage: decryption starts with the last round key
    logic        s0_valid_reg;
    logic        s0_func_reg;
    logic [63:0] s0_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (advance) begin
            s0_valid_reg <= s_valid && ks_status.ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s0_func_reg <= s_func;
            s0_data_reg <= (s_func == prst_pkg::FUNC_DECRYPT) ?
                           (s_data_block ^ rk[NR]) : s_data_block;
        end
    end

    assign stage[0].valid = s0_valid_reg;
    assign stage[0].func  = s0_func_reg;
    assign stage[0].data  = s0_data_reg;

    for (genvar j = 0; j < NR; j++) begin : g_round
        logic [63:0] fin_key;
        if (j == NR - 1) begin : g_last
            assign fin_key = rk[NR];
        end else begin : g_mid
            assign fin_key = '0;
        end

        prst_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (stage[j]),
            .enc_key   (rk[j]),
            .dec_key   (rk[NR - 1 - j]),
            .fin_key   (fin_key),
            .stage_out (stage[j + 1])
        );
    end

    assign m_valid        = stage[NR].valid;
    assign m_result_block = stage[NR].data;

endmodule

### rtl/prst_checker.sv
// Port-level checker for the cipher block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result_block,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready
);

    // A stalled result holds its value
    `PRST_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_result_block))

    // A key write closes the input while the round keys are rebuilt
    `PRST_ASSERT(a_key_block, aclk, aresetn, psel && penable && pwrite && pready |=> !s_ready)

    // Input only opens when the output side can move
    `PRST_ASSERT(a_ready_flow, aclk, aresetn, s_ready && m_valid |-> m_ready)

    // Reset empties the pipeline and starts a key rebuild
    `PRST_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid && !s_ready)

endmodule

bind present80_block_cipher_top prst_checker u_prst_checker (.*);

### test/tb_present80_block_cipher_top.sv
// Self-checking testbench for the PRESENT-80 encrypt/decrypt block.
`timescale 1ns / 1ps
module tb_present80_block_cipher_top;

    localparam int          RK_NUM   = 32;
    localparam int          LAT_WAIT = 40;
    localparam int          N_DIR    = 17;
    localparam int          N_PHASE  = 8;
    localparam int          PH_ITEMS = 50;
    localparam logic        FN_ENC   = prst_pkg::FUNC_ENCRYPT;
    localparam logic        FN_DEC   = prst_pkg::FUNC_DECRYPT;
    localparam logic [3:0]  ADDR_KEY_UPPER = {prst_pkg::IDX_KEY_UPPER, 3'b000};
    localparam logic [3:0]  ADDR_KEY_LOWER = {prst_pkg::IDX_KEY_LOWER, 3'b000};
    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [3:0]  SBOX_TAB [16] = '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA,
        4'hD, 4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};

    typedef struct {
        bit          set_key;
        logic [63:0] key_hi_w;
        logic [63:0] key_lo_w;
        logic        func;
        logic [63:0] blk;
        bit          known;
        logic [63:0] result;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [63:0] s_data_block;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_block;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    logic [3:0]  sbox_rev [16];
    logic [15:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] exp_rkeys [RK_NUM];
    logic [63:0] pending_blocks [$];
    dir_row_t    dir_tab [N_DIR];
    int          err_cnt = 0;
    int          burst_left;
    bit          vld_on;
    int          rdy_cyc = 0;

    present80_block_cipher_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_data_block   (s_data_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_block (m_result_block),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    // Round key schedule: rotate left 61, S-box top nibble, counter into 19..15.
    function automatic void load_round_keys();
        logic [79:0] k;
        int r;
        k = {key_hi, key_lo};
        for (r = 0; r < RK_NUM; r++) begin
            exp_rkeys[r] = k[79:16];
            k = (k << 61) | (k >> 19);
            k[79:76] = SBOX_TAB[k[79:76]];
            k[19:15] = k[19:15] ^ 5'(r + 1);
        end
    endfunction

    function automatic logic [63:0] sub_nibbles(input logic [63:0] x, input bit inv);
        logic [63:0] y;
        int n;
        for (n = 0; n < 16; n++) begin
            y[4*n +: 4] = inv ? sbox_rev[x[4*n +: 4]] : SBOX_TAB[x[4*n +: 4]];
        end
        return y;
    endfunction

    function automatic logic [63:0] spread_bits(input logic [63:0] x, input int mul);
        logic [63:0] y;
        int i;
        y = '0;
        y[63] = x[63];
        for (i = 0; i < 63; i++) begin
            y[(i * mul) % 63] = x[i];
        end
        return y;
    endfunction

    function automatic logic [63:0] cipher_block(input logic fn, input logic [63:0] blk);
        logic [63:0] b;
        int r;
        b = blk;
        if (fn == FN_ENC) begin
            for (r = 0; r < RK_NUM - 1; r++) begin
                b = spread_bits(sub_nibbles(b ^ exp_rkeys[r], 1'b0), 16);
            end
            b = b ^ exp_rkeys[RK_NUM-1];
        end else begin
            b = b ^ exp_rkeys[RK_NUM-1];
            for (r = RK_NUM - 2; r >= 0; r--) begin
                b = sub_nibbles(spread_bits(b, 4), 1'b1) ^ exp_rkeys[r];
            end
        end
        return b;
    endfunction

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_KEY_UPPER) begin
            key_hi = data[15:0];
        end else begin
            key_lo = data;
        end
        load_round_keys();
        // let the round key store rebuild
        repeat (LAT_WAIT) @(posedge aclk);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        if (vld_on) begin
            s_valid <= 1'b0;
            vld_on = 1'b0;
        end
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (LAT_WAIT) @(posedge aclk);
    endtask

    task automatic load_key(input logic [63:0] hi_w, input logic [63:0] lo_w);
        drain();
        if ($urandom_range(0, 1)) begin
            apb_write(ADDR_KEY_UPPER, hi_w);
            apb_write(ADDR_KEY_LOWER, lo_w);
        end else begin
            apb_write(ADDR_KEY_LOWER, lo_w);
            apb_write(ADDR_KEY_UPPER, hi_w);
        end
    endtask

    task automatic send_block(input logic fn, input logic [63:0] blk,
                              input logic [63:0] result);
        s_valid      <= 1'b1;
        s_func       <= fn;
        s_data_block <= blk;
        vld_on = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_blocks.push_back(result);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            vld_on = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    // Receiver stall pattern, chosen by bits 9..8 of a free-running cycle counter.
    always @(posedge aclk) begin
        rdy_cyc <= rdy_cyc + 1;
        case (rdy_cyc[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rdy_cyc[2:0] != 3'd0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time,
                         m_result_block);
                err_cnt++;
            end else if (m_result_block !== pending_blocks[0]) begin
                $display("%0t: result_block mismatch, expected %h actual %h", $time,
                         pending_blocks[0], m_result_block);
                err_cnt++;
                void'(pending_blocks.pop_front());
            end else begin
                void'(pending_blocks.pop_front());
            end
        end
    end

    initial begin
        #5ms;
        $display("** present80_block_cipher_top: FAILED **");
        $finish;
    end

    initial begin
        int          p;
        int          k;
        logic        fn;
        logic [63:0] blk;
        logic [63:0] hi_w;
        logic [63:0] lo_w;
        logic [63:0] last_out;
        logic        last_fn;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = 1'b0;
        s_data_block = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        vld_on       = 1'b0;
        burst_left   = 5;
        for (k = 0; k < 16; k++) begin
            sbox_rev[SBOX_TAB[k]] = 4'(k);
        end
        key_hi = '0;
        key_lo = '0;
        load_round_keys();

        // Published vectors first; the opening rows run on the key left by reset.
        dir_tab = '{
            '{0, 64'h0, 64'h0, FN_ENC, 64'h0, 1, 64'h5579C1387B228445},
            '{0, 64'h0, 64'h0, FN_ENC, ALL_ONES, 1, 64'hA112FFC72F68417B},
            '{0, 64'h0, 64'h0, FN_DEC, 64'h5579C1387B228445, 1, 64'h0},
            '{0, 64'h0, 64'h0, FN_DEC, 64'hA112FFC72F68417B, 1, ALL_ONES},
            '{0, 64'h0, 64'h0, FN_ENC, 64'h8000000000000001, 0, 64'h0},
            '{0, 64'h0, 64'h0, FN_DEC, 64'h0, 0, 64'h0},
            '{1, ALL_ONES, ALL_ONES, FN_ENC, 64'h0, 1, 64'hE72C46C0F5945049},
            '{0, 64'h0, 64'h0, FN_ENC, ALL_ONES, 1, 64'h3333DCD3213210D2},
            '{0, 64'h0, 64'h0, FN_DEC, 64'hE72C46C0F5945049, 1, 64'h0},
            '{0, 64'h0, 64'h0, FN_DEC, 64'h3333DCD3213210D2, 1, ALL_ONES},
            '{0, 64'h0, 64'h0, FN_ENC, 64'h0123456789ABCDEF, 0, 64'h0},
            // upper register bits above bit 15 must be dropped
            '{1, 64'hFFFFFFFFFFFF0000, 64'h1, FN_ENC, 64'hAAAAAAAAAAAAAAAA, 0, 64'h0},
            '{0, 64'h0, 64'h0, FN_DEC, 64'h5555555555555555, 0, 64'h0},
            '{1, 64'hA5A55A5AC3C38000, 64'h0, FN_ENC, 64'h7FFFFFFFFFFFFFFE, 0, 64'h0},
            '{0, 64'h0, 64'h0, FN_DEC, 64'h8000000000000000, 0, 64'h0},
            '{1, 64'h0000000000005A5A, 64'hDEADBEEF01234567, FN_ENC,
              64'hFEDCBA9876543210, 0, 64'h0},
            '{0, 64'h0, 64'h0, FN_DEC, 64'h0000000000000001, 0, 64'h0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            if (dir_tab[k].set_key) begin
                load_key(dir_tab[k].key_hi_w, dir_tab[k].key_lo_w);
            end
            send_block(dir_tab[k].func, dir_tab[k].blk,
                       dir_tab[k].known ? dir_tab[k].result
                                        : cipher_block(dir_tab[k].func, dir_tab[k].blk));
        end

        last_out = '0;
        last_fn  = FN_ENC;
        for (p = 0; p < N_PHASE; p++) begin
            case (p)
                0: begin
                    hi_w = '0;
                    lo_w = '0;
                end
                1: begin
                    hi_w = ALL_ONES;
                    lo_w = ALL_ONES;
                end
                default: begin
                    hi_w = {$urandom, $urandom};
                    lo_w = {$urandom, $urandom};
                end
            endcase
            load_key(hi_w, lo_w);
            for (k = 0; k < PH_ITEMS; k++) begin
                if (p == 3 && k == PH_ITEMS / 2) begin
                    drain();
                end
                fn = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 7))
                    0: blk = $urandom_range(0, 1) ? ALL_ONES : '0;
                    1: blk = 64'h1 << $urandom_range(0, 63);
                    // feed the previous output back through the opposite function
                    2, 3: begin
                        fn  = ~last_fn;
                        blk = last_out;
                    end
                    default: blk = {$urandom, $urandom};
                endcase
                last_fn  = fn;
                last_out = cipher_block(fn, blk);
                send_block(fn, blk, last_out);
            end
        end

        drain();
        if (err_cnt == 0) begin
            $display("** present80_block_cipher_top: PASSED **");
        end else begin
            $display("** present80_block_cipher_top: FAILED **");
        end
        $finish;
    end

endmodule
